>>> rtl/bdq_pkg.sv
// Shared types and defaults for the bounded deque with match count.
package bdq_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        OP_CREATE     = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_PUSH_BACK  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_COUNT      = 3'd5,
        OP_DESTROY    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_CREATED = 2'd1,
        ST_EMPTY       = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

endpackage

>>> rtl/bdq_ring.sv
// Ring storage: one write port, two registered read ports.
module bdq_ring #(
    parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr_a,
    input  logic [IDX_W-1:0]       rd_addr_b,
    output logic [VALUE_WIDTH-1:0] rd_data_a,
    output logic [VALUE_WIDTH-1:0] rd_data_b
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> rtl/bounded_deque_with_match_count.sv
// Top level of the bounded deque with match count.
//
// A double-ended queue of up to DEPTH signed entries kept as a ring in one
// memory, addressed by a front index and an entry count. Each accepted
// transfer carries one op (create, push/pop at either end, count matches
// of a key, destroy) and yields exactly one result transfer carrying the
// status, match count, both end values, occupancy and the exists flag.
// One item is in flight at a time. For create, destroy, push and pop,
// the accept cycle updates the pointers and writes a pushed entry, the
// read state then reads both ends from the memory, and the response
// state loads the output register. A match count over n stored
// entries walks them first; the walk uses one memory read port
// and visits one entry per cycle. in_stall is high from the cycle after
// an accept until the result has entered the output register; the block
// waits there while a previous result is still stalled downstream.
module bounded_deque_with_match_count #(
    parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic signed [VALUE_WIDTH-1:0] value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [CNT_W-1:0]              match_count,
    output logic signed [VALUE_WIDTH-1:0] front_value,
    output logic signed [VALUE_WIDTH-1:0] back_value,
    output logic [CNT_W-1:0]              occupancy,
    output logic                          exists
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = IDX_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_RESP
    } state_t;

    // sum of two ring positions (< 2*DEPTH) folded back into the ring
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : (p + IDX_W'(1));
    endfunction

    state_t                   state_reg;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     created_reg, created_next;
    bdq_pkg::status_t         status_reg, status_next;
    logic [VALUE_WIDTH-1:0]   key_reg;
    logic [CNT_W-1:0]         match_reg;
    logic [CNT_W-1:0]         scan_left_reg;
    logic [IDX_W-1:0]         scan_pos_reg;
    logic                     scan_pend_reg;

    logic                     out_valid_reg;
    bdq_pkg::status_t         out_status_reg;
    logic [CNT_W-1:0]         out_match_reg;
    logic [VALUE_WIDTH-1:0]   out_front_reg;
    logic [VALUE_WIDTH-1:0]   out_back_reg;
    logic [CNT_W-1:0]         out_occ_reg;
    logic                     out_exists_reg;

    logic                     accept;
    logic                     full_now;
    logic                     empty_now;
    logic [IDX_W-1:0]         front_dec;
    logic [IDX_W-1:0]         tail_pos;
    logic [IDX_W-1:0]         back_pos;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr_a;
    logic [VALUE_WIDTH-1:0]   rd_data_a;
    logic [VALUE_WIDTH-1:0]   rd_data_b;
    logic                     out_free;
    logic                     has_entries;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign full_now  = (count_reg == FULL_CNT);
    assign empty_now = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_IDX : (front_reg - IDX_W'(1));
    // slot just past the back entry, valid whenever the ring is not full
    assign tail_pos  = ring_wrap(SUM_W'(front_reg) + SUM_W'(count_reg));
    // back entry; meaningless on an empty ring, masked at the output
    assign back_pos  = ring_wrap(SUM_W'(front_reg) + SUM_W'(count_reg) - SUM_W'(1));

    // pointer update and status for the op being accepted
    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        created_next = created_reg;
        status_next  = bdq_pkg::ST_OK;
        wr_en        = 1'b0;
        wr_addr      = tail_pos;
        if (bdq_pkg::op_t'(op) == bdq_pkg::OP_CREATE)
        begin
            created_next = 1'b1;
            front_next   = '0;
            count_next   = '0;
        end
        else if (!created_reg)
        begin
            status_next = bdq_pkg::ST_NOT_CREATED;
        end
        else
        begin
            case (bdq_pkg::op_t'(op))
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                        wr_en      = accept;
                        wr_addr    = front_dec;
                    end
                end
                bdq_pkg::OP_PUSH_BACK:
                begin
                    if (full_now)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        wr_en      = accept;
                    end
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    if (empty_now)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        front_next = ring_inc(front_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    if (empty_now)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdq_pkg::OP_COUNT:
                begin
                    if (empty_now)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                end
                bdq_pkg::OP_DESTROY:
                begin
                    created_next = 1'b0;
                    front_next   = '0;
                    count_next   = '0;
                end
                default:
                begin
                    // unused op code: no change
                end
            endcase
        end
    end

    // memory read requests: walk during a count, both ends before a result
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = front_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                rd_en     = (scan_left_reg != '0);
                rd_addr_a = scan_pos_reg;
            end
            S_READ:
            begin
                rd_en = 1'b1;
            end
            S_IDLE, S_RESP:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    bdq_ring #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (value),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (back_pos),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign out_free    = !out_valid_reg || !out_stall;
    assign has_entries = created_reg && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            created_reg   <= 1'b0;
            scan_left_reg <= '0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output register drains independently of the sequencer;
            // in S_RESP the load below decides out_valid_reg instead
            if (out_valid_reg && !out_stall && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        front_reg     <= front_next;
                        count_reg     <= count_next;
                        created_reg   <= created_next;
                        status_reg    <= status_next;
                        key_reg       <= value;
                        match_reg     <= '0;
                        scan_left_reg <= count_reg;
                        scan_pos_reg  <= front_reg;
                        scan_pend_reg <= 1'b0;
                        if ((bdq_pkg::op_t'(op) == bdq_pkg::OP_COUNT)
                            && (status_next == bdq_pkg::ST_OK))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_SCAN:
                begin
                    // compare lags the read issue: it checks the data read in the cycle before
                    if (scan_pend_reg && (rd_data_a == key_reg))
                    begin
                        match_reg <= match_reg + CNT_W'(1);
                    end
                    scan_pend_reg <= (scan_left_reg != '0);
                    if (scan_left_reg != '0)
                    begin
                        scan_left_reg <= scan_left_reg - CNT_W'(1);
                        scan_pos_reg  <= ring_inc(scan_pos_reg);
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_match_reg  <= match_reg;
                        out_front_reg  <= has_entries ? rd_data_a : '0;
                        out_back_reg   <= has_entries ? rd_data_b : '0;
                        out_occ_reg    <= count_reg;
                        out_exists_reg <= created_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign match_count = out_match_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign occupancy   = out_occ_reg;
    assign exists      = out_exists_reg;

endmodule

>>> rtl/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
module bdq_checker #(
    parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [1:0]             status,
    input logic [CNT_W-1:0]       match_count,
    input logic [VALUE_WIDTH-1:0] front_value,
    input logic [VALUE_WIDTH-1:0] back_value,
    input logic [CNT_W-1:0]       occupancy,
    input logic                   exists
);

    // one item in flight: intake closes right after a transfer in
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("intake open right after a transfer");

    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (occupancy == '0)) |-> ((front_value == '0) && (back_value == '0)))
        else $error("end values nonzero on empty deque");

    a_absent_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !exists) |-> (occupancy == '0))
        else $error("occupancy without a deque");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (match_count != '0))
            |-> ((status == bdq_pkg::ST_OK) && (match_count <= occupancy)))
        else $error("match count out of bounds");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind bounded_deque_with_match_count bdq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_bdq_checker (.*);
